@@ rtl/core/kpsb_pkg.sv @@
// Package for the keypad scanner with key buffer: opcodes, status codes,
// constants and the result descriptor passed between the control and the top level.
// No dependencies.
package kpsb_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 8;
  localparam logic [7:0]  EMPTY_BYTE       = 8'hFF;
  localparam logic [15:0] LOCKOUT_RESET    = 16'd50000;
  localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ROW  = 2'd0,
    OP_REQ  = 2'd1,
    OP_READ = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STORED   = 3'd1,
    ST_NO_COL   = 3'd2,
    ST_LOCKED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_UNARMED  = 3'd5,
    ST_LOCK_END = 3'd6
  } status_t;

  // How the result word of one item is to be assembled
  typedef struct packed {
    logic    from_mem;    // read_data comes from the store read port
    logic    empty;       // read_data is the empty byte
    logic    read_valid;
    status_t status;
  } res_meta_t;

endpackage

@@ rtl/core/kpsb_if.sv @@
// Handshake channel interfaces for the keypad scanner: input word, result word
// and configuration write. Depends on nothing.
interface kpsb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] row_flags;
  logic [3:0] column_hits;
  modport source (output valid, output opcode, output row_flags, output column_hits,
                  input ready);
  modport sink (input valid, input opcode, input row_flags, input column_hits,
                output ready);
endinterface

interface kpsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [2:0] status;
  modport source (output valid, output read_data, output read_valid, output status,
                  input ready);
  modport sink (input valid, input read_data, input read_valid, input status,
                output ready);
endinterface

interface kpsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/keypad_scanner_with_key_buffer.sv @@
// Keypad scanner with key buffer, top level.
// A result word passes the store read stage and then the output register after its
// input word is accepted. Throughput: one word per cycle unless out_word stalls, set by
// the single store port pair; the output register lets a word enter while a result waits.
// Reset (rst_n, synchronous, active low) clears pointers, arming and lockout and sets
// lockout_ticks to 50000; store contents are undefined until written.
module keypad_scanner_with_key_buffer
  import kpsb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  kpsb_in_if.sink   in_word,
  kpsb_out_if.source out_word,
  kpsb_cfg_if.sink  cfg_word
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [15:0]   lockout_ticks_r;
  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data_r;
  res_meta_t     meta;
  res_meta_t     s1_meta_r;
  logic          s1_valid_r;
  logic          s1_adv;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_rv_r;
  status_t       out_status_r;
  logic [7:0]    s1_data;

  // Configuration register, always ready
  assign cfg_word.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_ticks_r <= LOCKOUT_RESET;
    end else if (cfg_word.valid) begin
      lockout_ticks_r <= cfg_word.data;
    end
  end

  // Accept when the read stage is empty or moves on this cycle
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !s1_valid_r || s1_adv;
  assign accept        = in_word.valid && in_word.ready;

  kpsb_ctrl #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (op_t'(in_word.opcode)),
    .row_flags    (in_word.row_flags),
    .column_hits  (in_word.column_hits),
    .lockout_ticks(lockout_ticks_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .meta         (meta)
  );

  kpsb_store #(
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data_r)
  );

  // Read stage: hold the descriptor while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
  end

  // Assemble the reply byte
  always_comb begin
    if (s1_meta_r.from_mem) begin
      s1_data = rd_data_r;
    end else if (s1_meta_r.empty) begin
      s1_data = EMPTY_BYTE;
    end else begin
      s1_data = 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r   <= s1_data;
      out_rv_r     <= s1_meta_r.read_valid;
      out_status_r <= s1_meta_r.status;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.read_data  = out_data_r;
  assign out_word.read_valid = out_rv_r;
  assign out_word.status     = out_status_r;

endmodule

@@ rtl/core/kpsb_store.sv @@
// Key store memory: one write port, one read port with registered read data.
// Depends on kpsb_pkg for the default depth.
module kpsb_store
  import kpsb_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  // Write the key byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold the byte until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/kpsb_ctrl.sv @@
// Control state of the keypad scanner: row and column pick, buffer pointers,
// reply arming and lockout counter. Depends on kpsb_pkg.
module kpsb_ctrl
  import kpsb_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  op_t           opcode,
  input  logic [3:0]    row_flags,
  input  logic [3:0]    column_hits,
  input  logic [15:0]   lockout_ticks,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output res_meta_t     meta
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [CW-1:0] rd_pos_r, rd_pos_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          armed_r, armed_nxt;
  logic          locked_r, locked_nxt;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic [15:0]   elapsed_inc;
  logic [1:0]    row;
  logic [1:0]    col;
  logic          col_hit;
  logic          drained;

  // Pick the lowest flagged row, row 3 by default
  always_comb begin
    if (row_flags[0]) begin
      row = 2'd0;
    end else if (row_flags[1]) begin
      row = 2'd1;
    end else if (row_flags[2]) begin
      row = 2'd2;
    end else begin
      row = 2'd3;
    end
  end

  // Pick the lowest hitting column
  always_comb begin
    col_hit = |column_hits;
    if (column_hits[0]) begin
      col = 2'd0;
    end else if (column_hits[1]) begin
      col = 2'd1;
    end else if (column_hits[2]) begin
      col = 2'd2;
    end else begin
      col = 2'd3;
    end
  end

  assign drained     = (rd_pos_r == fill_r);
  assign elapsed_inc = (elapsed_r < ELAPSED_MAX) ? elapsed_r + 16'd1 : elapsed_r;
  assign rd_addr     = rd_pos_r[AW-1:0];

  // Decode one word into state updates, store accesses and the result descriptor
  always_comb begin
    rd_pos_nxt      = rd_pos_r;
    fill_nxt        = fill_r;
    armed_nxt       = armed_r;
    locked_nxt      = locked_r;
    elapsed_nxt     = elapsed_r;
    wr_en           = 1'b0;
    wr_addr         = fill_r[AW-1:0];
    wr_data         = {4'd0, row, col};
    rd_en           = 1'b0;
    meta.from_mem   = 1'b0;
    meta.empty      = 1'b0;
    meta.read_valid = 1'b0;
    meta.status     = ST_OK;
    case (opcode)
      OP_ROW: begin
        if (locked_r) begin
          meta.status = ST_LOCKED;
        end else if (!col_hit) begin
          meta.status = ST_NO_COL;
        end else begin
          if (drained) begin
            wr_en       = accept;
            wr_addr     = '0;
            rd_pos_nxt  = '0;
            fill_nxt    = ONE_C;
            meta.status = ST_STORED;
          end else if (fill_r >= DEPTH_C) begin
            meta.status = ST_FULL;
          end else begin
            wr_en       = accept;
            fill_nxt    = fill_r + ONE_C;
            meta.status = ST_STORED;
          end
          locked_nxt  = 1'b1;
          elapsed_nxt = '0;
        end
      end
      OP_REQ: begin
        if (drained) begin
          wr_en      = accept;
          wr_addr    = '0;
          wr_data    = EMPTY_BYTE;
          rd_pos_nxt = '0;
          fill_nxt   = ONE_C;
        end
        armed_nxt = 1'b1;
      end
      OP_READ: begin
        if (armed_r) begin
          if (rd_pos_r < DEPTH_C) begin
            rd_en         = accept;
            meta.from_mem = 1'b1;
            rd_pos_nxt    = rd_pos_r + ONE_C;
          end else begin
            meta.empty = 1'b1;
          end
          meta.read_valid = 1'b1;
          armed_nxt       = 1'b0;
        end else begin
          meta.status = ST_UNARMED;
        end
      end
      OP_TICK: begin
        if (locked_r) begin
          if (elapsed_inc >= lockout_ticks) begin
            locked_nxt  = 1'b0;
            elapsed_nxt = '0;
            meta.status = ST_LOCK_END;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      default: begin
        meta.status = ST_OK;
      end
    endcase
  end

  // Advance the control state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r  <= '0;
      fill_r    <= '0;
      armed_r   <= 1'b0;
      locked_r  <= 1'b0;
      elapsed_r <= '0;
    end else if (accept) begin
      rd_pos_r  <= rd_pos_nxt;
      fill_r    <= fill_nxt;
      armed_r   <= armed_nxt;
      locked_r  <= locked_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
